// ===== sv/alcache_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Associative line cache package
// Shared widths, operation and status codes, the way lookup structs and the
// address-to-line helpers used by the cache top level and its way bank.
// ----------------------------------------------------------------------------
package alcache_pkg;

   localparam int LINE_WORDS = 10;
   localparam int ADDR_BITS  = 7;
   localparam int WORD_BITS  = 16;
   localparam int WAY_BITS   = 3;
   localparam int AGE_BITS   = 8;
   localparam int LINE_BITS  = 4;
   localparam int LINE_MAX   = ((1 << ADDR_BITS) - 1) / LINE_WORDS;

   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   // Operation codes carried on the mode field.
   localparam logic [2:0] MODE_READ  = 3'd0;
   localparam logic [2:0] MODE_WRITE = 3'd1;
   localparam logic [2:0] MODE_LOAD  = 3'd2;
   localparam logic [2:0] MODE_FILL  = 3'd3;
   localparam logic [2:0] MODE_PEEK  = 3'd4;

   // Result status codes.
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_BAD    = 2'd1;
   localparam logic [1:0] STATUS_MISS   = 2'd2;
   localparam logic [1:0] STATUS_VICTIM = 2'd3;

   // Lookup request from the top level to the way bank.
   typedef struct packed {
      logic                 update;     // commit tag and age changes this cycle
      logic                 is_access;  // read or write operation
      logic                 is_load;    // load line operation
      logic [ADDR_BITS-1:0] base;       // line base address to match
      logic [WAY_BITS-1:0]  peek_way;   // way whose tag is reported for peek
   } ways_req_type;

   // Lookup answer from the way bank.
   typedef struct packed {
      logic                 hit;
      logic [WAY_BITS-1:0]  hit_way;
      logic [WAY_BITS-1:0]  victim;
      logic [ADDR_BITS-1:0] peek_tag;
   } ways_rsp_type;

   // Line number of an address: the count of whole lines below it.
   function automatic logic [LINE_BITS-1:0] line_of(input logic [ADDR_BITS-1:0] addr);
      logic [LINE_BITS-1:0] k;
      k = '0;
      for (int i = 1; i <= LINE_MAX; i++) begin
         if (addr >= ADDR_BITS'(i * LINE_WORDS)) begin
            k = LINE_BITS'(i);
         end
      end
      return k;
   endfunction

   // First address of a line.
   function automatic logic [ADDR_BITS-1:0] line_base(input logic [LINE_BITS-1:0] k);
      return ADDR_BITS'({3'b000, k} * ADDR_BITS'(LINE_WORDS));
   endfunction

endpackage

// ===== sv/assoc_line_cache_age_replace_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Associative line cache with age replacement
// Fully associative write-through cache of ten-word lines with an age
// counter per way, a victim loader, word fill and raw slot peek.
// ----------------------------------------------------------------------------
// Each item is captured at the accepting edge, and in the following lookup
// cycle the tag compare, victim choice and age update run across all ways in
// parallel while the single data store port makes at most one read or write;
// the result is registered at the end of that cycle. A new item is taken once
// the lookup cycle is over and the result register is free or being emptied,
// so no new item is taken while one is in its lookup cycle. Every tag resets
// to zero and there are no line valid bits, so line zero hits straight after
// reset. The data store is cleared by reset through one valid flag per word,
// with no clearing pass: a word that has never been written reads as zero.
// Write hits are passed through to memory on the mem_write_enable, mem_address
// and mem_data fields.
// ----------------------------------------------------------------------------
module assoc_line_cache_age_replace_top #(
   parameter int WAYS      = 5,
   parameter int MEM_WORDS = 100,
   parameter int DATA_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [6:0]  req_address,
   input  logic [15:0] req_data,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_read_value,
   output logic [2:0]  rsp_way_index,
   output logic [6:0]  rsp_line_base,
   output logic        rsp_mem_write_enable,
   output logic [6:0]  rsp_mem_address,
   output logic [15:0] rsp_mem_data
);

   localparam int SLOTS   = WAYS * alcache_pkg::LINE_WORDS;
   localparam int SLOT_IW = $clog2(SLOTS);
   localparam int AW      = alcache_pkg::ADDR_BITS;
   localparam int DW      = alcache_pkg::WORD_BITS;
   localparam logic [DW-1:0] DATA_MASK =
      (DATA_BITS >= DW) ? {DW{1'b1}} : DW'((64'd1 << DATA_BITS) - 64'd1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LOOK = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // Captured item.
   logic [2:0]    mode_ff;
   logic [AW-1:0] addr_ff;
   logic [DW-1:0] data_ff;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff, status_in;
   logic [2:0]    way_ff, way_in;
   logic [AW-1:0] base_out_ff, base_out_in;
   logic          we_ff, we_in;
   logic [AW-1:0] ma_ff, ma_in;
   logic [DW-1:0] md_ff, md_in;
   logic          rd_use_ff, rd_use_in;
   logic [DW-1:0] mem_q_ff;

   // Data store and its per-word valid flags.
   logic [DW-1:0]    store_mem [SLOTS];
   logic [SLOTS-1:0] vld_ff;

   logic                          accept;
   logic                          looking;
   logic [alcache_pkg::LINE_BITS-1:0] line_k;
   logic [AW-1:0]                 base;
   logic [3:0]                    offset;
   logic                          addr_bad;
   logic                          peek_bad;
   logic [DW-1:0]                 data_m;
   logic [SLOT_IW-1:0]            hit_slot;
   logic [SLOT_IW-1:0]            acc_slot;
   logic                          rd_en;
   logic                          wr_en;

   alcache_pkg::ways_req_type lookup;
   alcache_pkg::ways_rsp_type answer;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign looking   = (state_ff == ST_LOOK);

   // Address decode: the line a memory address falls in and its offset.
   assign line_k   = alcache_pkg::line_of(addr_ff);
   assign base     = alcache_pkg::line_base(line_k);
   assign offset   = 4'(addr_ff - base);
   assign addr_bad = {1'b0, addr_ff} >= (AW + 1)'(MEM_WORDS);
   assign peek_bad = {1'b0, addr_ff} >= (AW + 1)'(SLOTS);
   assign data_m   = data_ff & DATA_MASK;
   assign hit_slot = SLOT_IW'({4'b0000, answer.hit_way} * AW'(alcache_pkg::LINE_WORDS)
                              + {3'b000, offset});

   assign lookup.update    = looking && !addr_bad && (mode_ff <= alcache_pkg::MODE_LOAD);
   assign lookup.is_access = (mode_ff == alcache_pkg::MODE_READ) ||
                             (mode_ff == alcache_pkg::MODE_WRITE);
   assign lookup.is_load   = (mode_ff == alcache_pkg::MODE_LOAD);
   assign lookup.base      = base;
   assign lookup.peek_way  = alcache_pkg::WAY_BITS'(line_k);

   alcache_ways #(
      .WAYS (WAYS)
   ) u_ways (
      .clock  (clock),
      .reset  (reset),
      .lookup (lookup),
      .answer (answer)
   );

   // Result of the item in the lookup cycle.
   always_comb begin
      status_in   = alcache_pkg::STATUS_OK;
      way_in      = '0;
      base_out_in = '0;
      we_in       = 1'b0;
      ma_in       = '0;
      md_in       = '0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      acc_slot    = hit_slot;
      case (mode_ff)
         alcache_pkg::MODE_READ,
         alcache_pkg::MODE_WRITE,
         alcache_pkg::MODE_FILL: begin
            if (addr_bad) begin
               status_in = alcache_pkg::STATUS_BAD;
            end else if (!answer.hit) begin
               status_in = alcache_pkg::STATUS_MISS;
            end else begin
               way_in = answer.hit_way;
               if (mode_ff == alcache_pkg::MODE_READ) begin
                  rd_en = 1'b1;
               end else begin
                  wr_en = 1'b1;
               end
               if (mode_ff == alcache_pkg::MODE_WRITE) begin
                  we_in = 1'b1;
                  ma_in = addr_ff;
                  md_in = data_m;
               end
            end
         end
         alcache_pkg::MODE_LOAD: begin
            if (addr_bad) begin
               status_in = alcache_pkg::STATUS_BAD;
            end else if (answer.hit) begin
               way_in      = answer.hit_way;
               base_out_in = base;
            end else begin
               status_in   = alcache_pkg::STATUS_VICTIM;
               way_in      = answer.victim;
               base_out_in = base;
            end
         end
         alcache_pkg::MODE_PEEK: begin
            if (peek_bad) begin
               status_in = alcache_pkg::STATUS_BAD;
            end else begin
               rd_en       = 1'b1;
               acc_slot    = addr_ff[SLOT_IW-1:0];
               way_in      = alcache_pkg::WAY_BITS'(line_k);
               base_out_in = answer.peek_tag;
            end
         end
         default: begin
            status_in = alcache_pkg::STATUS_BAD;
         end
      endcase
      // A word never written since reset reads as zero.
      rd_use_in = rd_en && vld_ff[acc_slot];
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (looking && wr_en) begin
            vld_ff[acc_slot] <= 1'b1;
         end
      end
   end

   // Item capture and result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         addr_ff <= req_address;
         data_ff <= req_data;
      end
      if (looking) begin
         status_ff   <= status_in;
         way_ff      <= way_in;
         base_out_ff <= base_out_in;
         we_ff       <= we_in;
         ma_ff       <= ma_in;
         md_ff       <= md_in;
         rd_use_ff   <= rd_use_in;
      end
   end

   // Data store: at most one access per item, read data registered.
   always_ff @(posedge clock) begin
      if (looking && wr_en) begin
         store_mem[acc_slot] <= data_m;
      end
      if (looking && rd_en) begin
         mem_q_ff <= store_mem[acc_slot];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_read_value       = rd_use_ff ? mem_q_ff : '0;
   assign rsp_way_index        = way_ff;
   assign rsp_line_base        = base_out_ff;
   assign rsp_mem_write_enable = we_ff;
   assign rsp_mem_address      = ma_ff;
   assign rsp_mem_data         = md_ff;

endmodule

// ===== sv/alcache_ways.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Associative line cache way bank
// Holds the tag and age counter of every way, matches a line base against
// all tags, picks the victim and applies the age raise and settle.
// ----------------------------------------------------------------------------
module alcache_ways #(
   parameter int WAYS = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  alcache_pkg::ways_req_type lookup,
   output alcache_pkg::ways_rsp_type answer
);

   logic [alcache_pkg::ADDR_BITS-1:0] tags_ff [WAYS];
   logic [alcache_pkg::ADDR_BITS-1:0] tags_in [WAYS];
   logic [alcache_pkg::AGE_BITS-1:0]  ages_ff [WAYS];
   logic [alcache_pkg::AGE_BITS-1:0]  ages_in [WAYS];
   logic [alcache_pkg::AGE_BITS-1:0]  ages_mid [WAYS];

   logic                              hit;
   logic [alcache_pkg::WAY_BITS-1:0]  hit_way;
   logic [alcache_pkg::AGE_BITS-1:0]  hit_age;
   logic [alcache_pkg::WAY_BITS-1:0]  victim;
   logic [alcache_pkg::AGE_BITS-1:0]  victim_age;
   logic [alcache_pkg::AGE_BITS-1:0]  max_age;
   logic [alcache_pkg::AGE_BITS-1:0]  new_age;
   logic [alcache_pkg::WAY_BITS-1:0]  raise_way;
   logic                              raise_en;
   logic                              any_one;
   logic [alcache_pkg::ADDR_BITS-1:0] peek_tag;

   always_comb begin
      hit        = 1'b0;
      hit_way    = '0;
      hit_age    = '0;
      max_age    = ages_ff[0];
      victim     = '0;
      victim_age = ages_ff[0];
      peek_tag   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!hit && tags_ff[w] == lookup.base) begin
            hit     = 1'b1;
            hit_way = alcache_pkg::WAY_BITS'(w);
            hit_age = ages_ff[w];
         end
         if (ages_ff[w] > max_age) begin
            max_age = ages_ff[w];
         end
         if (ages_ff[w] < victim_age) begin
            victim     = alcache_pkg::WAY_BITS'(w);
            victim_age = ages_ff[w];
         end
         if (lookup.peek_way == alcache_pkg::WAY_BITS'(w)) begin
            peek_tag = tags_ff[w];
         end
      end
   end

   // A new line, or a read or write hit that is not already the newest, gets the top age.
   assign new_age   = (max_age == alcache_pkg::AGE_MAX) ? alcache_pkg::AGE_MAX
                                                        : max_age + 1'b1;
   assign raise_way = lookup.is_load ? victim : hit_way;
   assign raise_en  = lookup.update &&
                      ((lookup.is_load && !hit) ||
                       (lookup.is_access && hit && hit_age != max_age));

   always_comb begin
      any_one = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         tags_in[w]  = tags_ff[w];
         ages_mid[w] = ages_ff[w];
         if (raise_en && raise_way == alcache_pkg::WAY_BITS'(w)) begin
            ages_mid[w] = new_age;
            if (lookup.is_load) begin
               tags_in[w] = lookup.base;
            end
         end
         if (ages_mid[w] == alcache_pkg::AGE_BITS'(1)) begin
            any_one = 1'b1;
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         ages_in[w] = ages_mid[w];
         if (raise_en && !any_one && ages_mid[w] != '0) begin
            ages_in[w] = ages_mid[w] - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < WAYS; w++) begin
            tags_ff[w] <= '0;
            ages_ff[w] <= '0;
         end
      end else begin
         for (int w = 0; w < WAYS; w++) begin
            tags_ff[w] <= tags_in[w];
            ages_ff[w] <= ages_in[w];
         end
      end
   end

   assign answer.hit      = hit;
   assign answer.hit_way  = hit_way;
   assign answer.victim   = victim;
   assign answer.peek_tag = peek_tag;

endmodule

// ===== test/alcache_reply_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Associative line cache reply checker
// Watches the request and reply channels of the cache, keeps its own copy of
// the tags, ages and data words, and compares every reply field by field.
// ----------------------------------------------------------------------------
module alcache_reply_checker #(
   parameter int WAYS      = 5,
   parameter int MEM_WORDS = 100
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [6:0]  req_address,
   input  logic [15:0] req_data,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [15:0] rsp_read_value,
   input  logic [2:0]  rsp_way_index,
   input  logic [6:0]  rsp_line_base,
   input  logic        rsp_mem_write_enable,
   input  logic [6:0]  rsp_mem_address,
   input  logic [15:0] rsp_mem_data,

   output int          mismatch_count,
   output int          replies_pending
);

   typedef struct packed {
      logic [1:0]                       status;
      logic [alcache_pkg::WORD_BITS-1:0] read_value;
      logic [alcache_pkg::WAY_BITS-1:0]  way_index;
      logic [alcache_pkg::ADDR_BITS-1:0] base;
      logic                             mem_we;
      logic [alcache_pkg::ADDR_BITS-1:0] mem_addr;
      logic [alcache_pkg::WORD_BITS-1:0] mem_data;
   } cache_reply_type;

   logic [alcache_pkg::ADDR_BITS-1:0] way_tag   [WAYS];
   logic [alcache_pkg::AGE_BITS-1:0]  way_age   [WAYS];
   logic [alcache_pkg::WORD_BITS-1:0] slot_word [WAYS*alcache_pkg::LINE_WORDS];
   cache_reply_type                   replies_due[$];

   function automatic logic [alcache_pkg::AGE_BITS-1:0] newest_age();
      logic [alcache_pkg::AGE_BITS-1:0] top;
      top = way_age[0];
      for (int w = 1; w < WAYS; w++) begin
         if (way_age[w] > top) begin
            top = way_age[w];
         end
      end
      return top;
   endfunction

   // Make a way the newest, then pull every nonzero age down by one if none is left at one.
   function automatic void promote_way(input int w);
      logic [alcache_pkg::AGE_BITS-1:0] top;
      bit                               seen_one;
      top = newest_age();
      way_age[w] = (top == alcache_pkg::AGE_MAX) ? alcache_pkg::AGE_MAX : top + 1'b1;
      seen_one = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
         if (way_age[i] == 1) begin
            seen_one = 1'b1;
         end
      end
      if (!seen_one) begin
         for (int i = 0; i < WAYS; i++) begin
            if (way_age[i] != 0) begin
               way_age[i] = way_age[i] - 1'b1;
            end
         end
      end
   endfunction

   function automatic cache_reply_type cache_apply(input logic [2:0] mode,
                                                   input logic [6:0] addr,
                                                   input logic [15:0] data);
      cache_reply_type                   r;
      int                                hit;
      int                                victim;
      int                                off;
      int                                slot;
      logic [alcache_pkg::ADDR_BITS-1:0] base;
      r = '0;
      if (mode <= alcache_pkg::MODE_FILL) begin
         if (addr >= MEM_WORDS) begin
            r.status = alcache_pkg::STATUS_BAD;
         end else begin
            off  = addr % alcache_pkg::LINE_WORDS;
            base = alcache_pkg::ADDR_BITS'(addr - off);
            hit  = -1;
            for (int w = WAYS - 1; w >= 0; w--) begin
               if (way_tag[w] == base) begin
                  hit = w;
               end
            end
            if (mode == alcache_pkg::MODE_LOAD) begin
               if (hit >= 0) begin
                  r.way_index = alcache_pkg::WAY_BITS'(hit);
                  r.base      = base;
               end else begin
                  victim = 0;
                  for (int i = 1; i < WAYS; i++) begin
                     if (way_age[i] < way_age[victim]) begin
                        victim = i;
                     end
                  end
                  way_tag[victim] = base;
                  promote_way(victim);
                  r.status    = alcache_pkg::STATUS_VICTIM;
                  r.way_index = alcache_pkg::WAY_BITS'(victim);
                  r.base      = base;
               end
            end else if (hit < 0) begin
               r.status = alcache_pkg::STATUS_MISS;
            end else begin
               slot = hit * alcache_pkg::LINE_WORDS + off;
               r.way_index = alcache_pkg::WAY_BITS'(hit);
               if (mode == alcache_pkg::MODE_READ) begin
                  r.read_value = slot_word[slot];
               end else begin
                  slot_word[slot] = data;
                  if (mode == alcache_pkg::MODE_WRITE) begin
                     r.mem_we   = 1'b1;
                     r.mem_addr = addr;
                     r.mem_data = data;
                  end
               end
               // A fill leaves the ages alone.
               if (mode != alcache_pkg::MODE_FILL && newest_age() != way_age[hit]) begin
                  promote_way(hit);
               end
            end
         end
      end else if (mode == alcache_pkg::MODE_PEEK) begin
         if (addr >= WAYS * alcache_pkg::LINE_WORDS) begin
            r.status = alcache_pkg::STATUS_BAD;
         end else begin
            r.read_value = slot_word[addr];
            r.way_index  = alcache_pkg::WAY_BITS'(addr / alcache_pkg::LINE_WORDS);
            r.base       = way_tag[addr / alcache_pkg::LINE_WORDS];
         end
      end else begin
         r.status = alcache_pkg::STATUS_BAD;
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      cache_reply_type want;
      if (reset) begin
         for (int w = 0; w < WAYS; w++) begin
            way_tag[w] = '0;
            way_age[w] = '0;
         end
         for (int s = 0; s < WAYS * alcache_pkg::LINE_WORDS; s++) begin
            slot_word[s] = '0;
         end
         replies_due.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               $display("%0t: reply with none expected, status %0d", $time, rsp_status);
               mismatch_count++;
            end else begin
               want = replies_due.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("read_value", want.read_value, rsp_read_value);
               check_field("way_index", want.way_index, rsp_way_index);
               check_field("line_base", want.base, rsp_line_base);
               check_field("mem_write_enable", want.mem_we, rsp_mem_write_enable);
               check_field("mem_address", want.mem_addr, rsp_mem_address);
               check_field("mem_data", want.mem_data, rsp_mem_data);
            end
         end
         if (req_valid && req_ready) begin
            replies_due.push_back(cache_apply(req_mode, req_address, req_data));
         end
      end
      replies_pending <= replies_due.size();
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Associative line cache testbench
// Drives directed and random operations into the cache with random idling on
// both channels, and leaves prediction and comparison to the reply checker.
// ----------------------------------------------------------------------------
module tb;

   localparam int WAYS        = 5;
   localparam int MEM_WORDS   = 100;
   localparam int SLOTS       = WAYS * alcache_pkg::LINE_WORDS;
   localparam int ITEM_GOAL   = 930;
   localparam int HOLD_CYCLES = 80;
   localparam int HOLD_AT     = 300;
   localparam int BURST_FROM  = 420;
   localparam int BURST_TO    = 500;
   localparam int DRAIN_AT    = 600;

   // The highest code the mode field can carry; everything above peek is unused.
   localparam logic [2:0] MODE_TOP = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode    = alcache_pkg::MODE_READ;
   logic [6:0]  req_address = '0;
   logic [15:0] req_data    = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_read_value;
   logic [2:0]  rsp_way_index;
   logic [6:0]  rsp_line_base;
   logic        rsp_mem_write_enable;
   logic [6:0]  rsp_mem_address;
   logic [15:0] rsp_mem_data;

   int          mismatch_count;
   int          replies_pending;

   // Shared between the sender and the receiver: a request for one long
   // hold-off on the reply side, and a stretch in which neither side idles.
   bit          hold_request = 1'b0;
   bit          full_rate    = 1'b0;
   int          items_sent   = 0;

   always #2 clock = ~clock;

   assoc_line_cache_age_replace_top #(
      .WAYS      (WAYS),
      .MEM_WORDS (MEM_WORDS),
      .DATA_BITS (alcache_pkg::WORD_BITS)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_address          (req_address),
      .req_data             (req_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_read_value       (rsp_read_value),
      .rsp_way_index        (rsp_way_index),
      .rsp_line_base        (rsp_line_base),
      .rsp_mem_write_enable (rsp_mem_write_enable),
      .rsp_mem_address      (rsp_mem_address),
      .rsp_mem_data         (rsp_mem_data)
   );

   alcache_reply_checker #(
      .WAYS      (WAYS),
      .MEM_WORDS (MEM_WORDS)
   ) reply_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_address          (req_address),
      .req_data             (req_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_read_value       (rsp_read_value),
      .rsp_way_index        (rsp_way_index),
      .rsp_line_base        (rsp_line_base),
      .rsp_mem_write_enable (rsp_mem_write_enable),
      .rsp_mem_address      (rsp_mem_address),
      .rsp_mem_data         (rsp_mem_data),
      .mismatch_count       (mismatch_count),
      .replies_pending      (replies_pending)
   );

   // Most gaps are nil or short, with the occasional long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Data words lean towards all zeros and all ones now and then.
   function automatic logic [15:0] pick_word();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return '0;
      end else if (r == 1) begin
         return '1;
      end
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   // Offers one item, waits for the handshake, then, outside the full-rate stretch,
   // idles for a random gap. The valid line is only lowered when a gap follows,
   // so back-to-back items keep it high without a glitch.
   task automatic offer(input logic [2:0] mode, input logic [6:0] addr,
                        input logic [15:0] data);
      int gap;
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_address <= addr;
      req_data    <= data;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      gap = full_rate ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // A well-formed use of one line: claim it, fill some of its words, then
   // read and write it, sometimes straying to another line, and now and then peek a raw slot.
   task automatic line_session();
      int base;
      int other;
      int n;
      base = 10 * $urandom_range(0, 9);
      offer(alcache_pkg::MODE_LOAD, 7'(base + $urandom_range(0, 9)), pick_word());
      n = $urandom_range(0, 10);
      repeat (n) offer(alcache_pkg::MODE_FILL, 7'(base + $urandom_range(0, 9)), pick_word());
      n = $urandom_range(1, 6);
      repeat (n) begin
         other = ($urandom_range(0, 3) == 0) ? 10 * $urandom_range(0, 9) : base;
         offer($urandom_range(0, 1) ? alcache_pkg::MODE_WRITE : alcache_pkg::MODE_READ,
               7'(other + $urandom_range(0, 9)), pick_word());
      end
      if ($urandom_range(0, 3) == 0) begin
         offer(alcache_pkg::MODE_PEEK, 7'($urandom_range(0, SLOTS - 1)), pick_word());
      end
   endtask

   // Reply side. Ready runs in bursts separated by random stalls; on request
   // it holds off for a long count of cycles so that the cache backs up and
   // stops taking requests. Exactly one assignment is made per clock edge.
   initial begin
      int hold_left;
      int run_left;
      int stall_left;
      hold_left  = 0;
      run_left   = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_ready   <= 1'b0;
         end else if (full_rate) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (run_left > 0) begin
            rsp_ready <= 1'b1;
            run_left--;
         end else begin
            run_left   = $urandom_range(0, 12);
            stall_left = pick_gap();
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      bit hold_done;
      bit drain_done;
      hold_done  = 1'b0;
      drain_done = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Every tag starts at zero, so line zero hits in the lowest way at once.
      offer(alcache_pkg::MODE_READ,  7'd0,  16'h0000);
      offer(alcache_pkg::MODE_WRITE, 7'd9,  16'hFFFF);
      offer(alcache_pkg::MODE_READ,  7'd9,  16'h0000);
      offer(alcache_pkg::MODE_WRITE, 7'd0,  16'h0000);
      // Misses on an absent line, and a fill of an absent line.
      offer(alcache_pkg::MODE_READ,  7'd99, 16'h5A5A);
      offer(alcache_pkg::MODE_WRITE, 7'd99, 16'h1234);
      offer(alcache_pkg::MODE_FILL,  7'd45, 16'hBEEF);
      // Loading a line that is already present changes nothing.
      offer(alcache_pkg::MODE_LOAD,  7'd0,  16'h0000);
      // A real load takes a victim; line zero still hits in the next way up,
      // which exercises the case of several ways holding the same tag.
      offer(alcache_pkg::MODE_LOAD,  7'd93, 16'h0000);
      offer(alcache_pkg::MODE_FILL,  7'd99, 16'hAAAA);
      offer(alcache_pkg::MODE_READ,  7'd99, 16'h0000);
      offer(alcache_pkg::MODE_READ,  7'd5,  16'h0000);
      offer(alcache_pkg::MODE_WRITE, 7'd3,  16'h8001);
      // Memory addresses out of range for each of the four address modes.
      offer(alcache_pkg::MODE_READ,  7'd100, 16'hFFFF);
      offer(alcache_pkg::MODE_WRITE, 7'd127, 16'hFFFF);
      offer(alcache_pkg::MODE_LOAD,  7'd127, 16'h0000);
      offer(alcache_pkg::MODE_FILL,  7'd100, 16'h7FFF);
      // Raw slot reads at both ends, and just past the store.
      offer(alcache_pkg::MODE_PEEK,  7'd0,   16'h0000);
      offer(alcache_pkg::MODE_PEEK,  7'd9,   16'h0000);
      offer(alcache_pkg::MODE_PEEK,  7'(SLOTS - 1), 16'h0000);
      offer(alcache_pkg::MODE_PEEK,  7'(SLOTS), 16'h0000);
      offer(alcache_pkg::MODE_PEEK,  7'd127, 16'hFFFF);
      // The unused mode codes.
      for (int m = alcache_pkg::MODE_PEEK + 1; m <= MODE_TOP; m++) begin
         offer(3'(m), 7'd127, 16'hFFFF);
      end

      while (items_sent < ITEM_GOAL) begin
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done    = 1'b1;
            hold_request = 1'b1;
         end
         // Once in the run the sender stops until every reply has come back.
         if (!drain_done && items_sent >= DRAIN_AT) begin
            drain_done = 1'b1;
            req_valid <= 1'b0;
            do @(posedge clock); while (replies_pending != 0);
         end
         full_rate = (items_sent >= BURST_FROM && items_sent < BURST_TO);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               line_session();
            end
            6, 7: begin
               offer($urandom_range(0, 1) ? alcache_pkg::MODE_WRITE : alcache_pkg::MODE_READ,
                     7'($urandom_range(0, 9) == 0 ? $urandom_range(MEM_WORDS, 127)
                                                  : $urandom_range(0, MEM_WORDS - 1)),
                     pick_word());
            end
            8: begin
               offer(alcache_pkg::MODE_PEEK, 7'($urandom_range(0, SLOTS + 9)), pick_word());
            end
            default: begin
               offer(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                     16'($urandom_range(0, 16'hFFFF)));
            end
         endcase
      end
      full_rate = 1'b0;

      req_valid <= 1'b0;
      do @(posedge clock); while (replies_pending != 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   // Guard against a hang: far longer than the slowest legal run needs.
   initial begin
      #2_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
